// File: hdl/ale_pkg.sv
// Shared types, constants and sign helpers for the associated Legendre evaluator.
// Used by ale_unit and assoc_legendre_eval_top; depends on nothing.
package ale_pkg;

    // fixed-point constants
    localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
    localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;
    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
    localparam logic signed [63:0] VAL_MAX = 64'sh007F_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] VAL_MIN = -64'sh0080_0000_0000_0000;

    // operations of the shared unit
    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } unit_op_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQRT,
        ST_PMM_C,
        ST_PMM_S,
        ST_CHK,
        ST_PH_C,
        ST_PH_X,
        ST_RCHK,
        ST_RA_C,
        ST_RA_X,
        ST_RB_C,
        ST_RDIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic        start;
        unit_op_t    op;
        logic        rnd;    // MUL: add 2^29 and shift right by 30
        logic [63:0] opa;
        logic [30:0] opb;    // MUL multiplier, DIV divisor in low 4 bits
    } unit_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } unit_rsp_t;

    function automatic logic [63:0] mag(input logic [63:0] v);
        mag = v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic logic [63:0] with_sign(input logic [63:0] m, input logic neg);
        with_sign = neg ? (64'd0 - m) : m;
    endfunction

endpackage

// File: hdl/ale_unit.sv
// Shared iterative arithmetic unit: shift-add multiply, restoring divide, square root.
// Depends on ale_pkg for the request/response structs and operation codes.
module ale_unit
(
    input  logic              clk,
    input  logic              rst_n,
    input  ale_pkg::unit_req_t req,
    output ale_pkg::unit_rsp_t rsp
);

    logic                busy_reg, busy_next;
    ale_pkg::unit_op_t   op_reg, op_next;
    logic                rnd_reg, rnd_next;
    logic [94:0]         acc_reg, acc_next;
    logic [94:0]         ash_reg, ash_next;
    logic [30:0]         bsh_reg, bsh_next;
    logic [60:0]         bit_reg, bit_next;
    logic [3:0]          rem_reg, rem_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [63:0]         res_reg, res_next;

    logic [4:0]          trial;
    logic                qbit;
    logic [61:0]         t_sum;
    logic [60:0]         srem;
    logic [60:0]         sroot;

    // next-state logic for the three iterative operations
    always_comb
    begin
        busy_next = busy_reg;
        op_next   = op_reg;
        rnd_next  = rnd_reg;
        acc_next  = acc_reg;
        ash_next  = ash_reg;
        bsh_next  = bsh_reg;
        bit_next  = bit_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        trial     = {rem_reg, acc_reg[63]};
        qbit      = 1'b0;
        t_sum     = {1'b0, ash_reg[60:0]} + {1'b0, bit_reg};
        srem      = acc_reg[60:0];
        sroot     = ash_reg[60:0] >> 1;
        if (req.start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            rnd_next  = req.rnd;
            cnt_next  = 6'd0;
            rem_next  = 4'd0;
            bsh_next  = req.opb;
            bit_next  = 61'd1 << 60;
            case (req.op)
                ale_pkg::OP_MUL:
                begin
                    acc_next = req.rnd ? (95'd1 << 29) : 95'd0;
                    ash_next = {31'd0, req.opa};
                end
                ale_pkg::OP_DIV:
                begin
                    acc_next = {31'd0, req.opa + {61'd0, req.opb[3:1]}};
                    ash_next = 95'd0;
                end
                default:
                begin
                    acc_next = {34'd0, req.opa[60:0]};
                    ash_next = 95'd0;
                end
            endcase
        end
        else if (busy_reg)
        begin
            case (op_reg)
                ale_pkg::OP_MUL:
                begin
                    if (bsh_reg == 31'd0)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                        res_next  = rnd_reg ? acc_reg[93:30] : acc_reg[63:0];
                    end
                    else
                    begin
                        if (bsh_reg[0])
                        begin
                            acc_next = acc_reg + ash_reg;
                        end
                        ash_next = ash_reg << 1;
                        bsh_next = bsh_reg >> 1;
                    end
                end
                ale_pkg::OP_DIV:
                begin
                    // one quotient bit per cycle, MSB first
                    if (trial >= {1'b0, bsh_reg[3:0]})
                    begin
                        qbit     = 1'b1;
                        rem_next = 4'(trial - {1'b0, bsh_reg[3:0]});
                    end
                    else
                    begin
                        rem_next = trial[3:0];
                    end
                    acc_next = {31'd0, acc_reg[62:0], qbit};
                    cnt_next = cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                        res_next  = {acc_reg[62:0], qbit};
                    end
                end
                default:
                begin
                    // digit-by-digit root, two radicand bits per cycle
                    if ({1'b0, acc_reg[60:0]} >= t_sum)
                    begin
                        srem  = 61'(({1'b0, acc_reg[60:0]}) - t_sum);
                        sroot = (ash_reg[60:0] >> 1) + bit_reg;
                    end
                    acc_next = {34'd0, srem};
                    ash_next = {34'd0, sroot};
                    bit_next = bit_reg >> 2;
                    cnt_next = cnt_reg + 6'd1;
                    if (cnt_reg == 6'd30)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                        res_next  = (srem > sroot) ? {3'd0, sroot + 61'd1} : {3'd0, sroot};
                    end
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= ale_pkg::OP_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rnd_reg <= rnd_next;
        acc_reg <= acc_next;
        ash_reg <= ash_next;
        bsh_reg <= bsh_next;
        bit_reg <= bit_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

endmodule

// File: hdl/assoc_legendre_eval_top.sv
// Top level of the associated Legendre evaluator: input capture, sequencer, output register.
// Depends on ale_pkg and ale_unit.
//
// Input items arrive on s_tvalid/s_tready/s_tdata (degree l, order m, argument x in Q2.30).
// Each item yields one result item on m_tvalid/m_tready/m_tdata with m_tuser = bad_args;
// the value is P^m_l(x) with 32 fraction bits, zero when the arguments are bad.
// s_tready is high only while the sequencer is idle: one item is worked on at a time.
// The work runs on one shared iterative unit: a multiply steps through the multiplier
// bits (up to 31 for x or s, 1 to 4 for an integer coefficient), a divide and the square
// root run bit by bit, each with a handoff to and from the sequencer.
// An item with bad arguments goes straight to the output stage.
// s_tready returns the cycle after the result is loaded.
// A finished result waits in the output register; the next item can be accepted
// meanwhile, and its result waits in the sequencer until the register frees.
// Reset clears the sequencer and the output valid; no clearing pass is needed.
module assoc_legendre_eval_top
#(
    parameter int L_MAX = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // degree[3:0], order[7:4], arg_x[39:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // value[55:0]
    output logic        m_tuser    // bad_args
);

    ale_pkg::state_t     state_reg, state_next;
    logic                issued_reg, issued_next;
    logic [3:0]          l_reg, l_next;
    logic [3:0]          m_reg, m_next;
    logic [31:0]         x_reg, x_next;
    logic [3:0]          k_reg, k_next;
    logic [3:0]          i_reg, i_next;
    logic [63:0]         plo_reg, plo_next;
    logic [63:0]         phi_reg, phi_next;
    logic [63:0]         a_reg, a_next;
    logic [30:0]         s_reg, s_next;
    logic [63:0]         res_reg, res_next;
    logic                bad_reg, bad_next;
    logic                ov_reg, ov_next;
    logic [55:0]         od_reg, od_next;
    logic                ob_reg, ob_next;

    ale_pkg::unit_req_t  u_req;
    ale_pkg::unit_rsp_t  u_rsp;

    logic [3:0]          in_l;
    logic [3:0]          in_m;
    logic signed [31:0]  in_x;
    logic                in_bad;
    logic [63:0]         ux;
    logic [63:0]         sat;

    assign in_l   = s_tdata[3:0];
    assign in_m   = s_tdata[7:4];
    assign in_x   = s_tdata[39:8];
    assign in_bad = (in_m > in_l) || (in_l > 4'(L_MAX)) ||
                    (in_x > ale_pkg::ONE_Q30) || (in_x < -ale_pkg::ONE_Q30);
    assign ux     = ale_pkg::mag({{32{x_reg[31]}}, x_reg});

    // saturate to the 56-bit result range
    always_comb
    begin
        if ($signed(res_reg) > ale_pkg::VAL_MAX)
        begin
            sat = ale_pkg::VAL_MAX;
        end
        else if ($signed(res_reg) < ale_pkg::VAL_MIN)
        begin
            sat = ale_pkg::VAL_MIN;
        end
        else
        begin
            sat = res_reg;
        end
    end

    ale_unit u_unit
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (u_req),
        .rsp   (u_rsp)
    );

    // sequencer: next state, unit requests and datapath updates
    always_comb
    begin
        state_next  = state_reg;
        issued_next = issued_reg;
        l_next      = l_reg;
        m_next      = m_reg;
        x_next      = x_reg;
        k_next      = k_reg;
        i_next      = i_reg;
        plo_next    = plo_reg;
        phi_next    = phi_reg;
        a_next      = a_reg;
        s_next      = s_reg;
        res_next    = res_reg;
        bad_next    = bad_reg;
        ov_next     = ov_reg;
        od_next     = od_reg;
        ob_next     = ob_reg;
        u_req.start = 1'b0;
        u_req.op    = ale_pkg::OP_MUL;
        u_req.rnd   = 1'b0;
        u_req.opa   = 64'd0;
        u_req.opb   = 31'd0;

        if (ov_reg && m_tready)
        begin
            ov_next = 1'b0;
        end

        // every unit-driven state issues once and waits for done
        if (state_reg != ale_pkg::ST_IDLE && state_reg != ale_pkg::ST_CHK &&
            state_reg != ale_pkg::ST_RCHK && state_reg != ale_pkg::ST_OUT)
        begin
            u_req.start = !issued_reg;
            issued_next = 1'b1;
            if (u_rsp.done)
            begin
                issued_next = 1'b0;
            end
        end

        case (state_reg)
            ale_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    l_next   = in_l;
                    m_next   = in_m;
                    x_next   = in_x;
                    plo_next = ale_pkg::ONE_Q32;
                    i_next   = 4'd1;
                    bad_next = in_bad;
                    res_next = 64'd0;
                    if (in_bad)
                    begin
                        state_next = ale_pkg::ST_OUT;
                    end
                    else if (in_m == 4'd0)
                    begin
                        state_next = ale_pkg::ST_CHK;
                    end
                    else
                    begin
                        state_next = ale_pkg::ST_SQ;
                    end
                end
            end
            ale_pkg::ST_SQ:
            begin
                // x^2, exact with 60 fraction bits
                u_req.op  = ale_pkg::OP_MUL;
                u_req.opa = ux;
                u_req.opb = ux[30:0];
                if (u_rsp.done)
                begin
                    a_next     = ale_pkg::ONE_Q60 - u_rsp.res;
                    state_next = ale_pkg::ST_SQRT;
                end
            end
            ale_pkg::ST_SQRT:
            begin
                u_req.op  = ale_pkg::OP_SQRT;
                u_req.opa = a_reg;
                if (u_rsp.done)
                begin
                    s_next     = u_rsp.res[30:0];
                    state_next = ale_pkg::ST_PMM_C;
                end
            end
            ale_pkg::ST_PMM_C:
            begin
                // times the odd factor 2i-1
                u_req.op  = ale_pkg::OP_MUL;
                u_req.opa = ale_pkg::mag(plo_reg);
                u_req.opb = {26'd0, 5'({i_reg, 1'b0}) - 5'd1};
                if (u_rsp.done)
                begin
                    a_next     = ale_pkg::with_sign(u_rsp.res, plo_reg[63]);
                    state_next = ale_pkg::ST_PMM_S;
                end
            end
            ale_pkg::ST_PMM_S:
            begin
                // times s, negated
                u_req.op  = ale_pkg::OP_MUL;
                u_req.rnd = 1'b1;
                u_req.opa = ale_pkg::mag(a_reg);
                u_req.opb = s_reg;
                if (u_rsp.done)
                begin
                    plo_next = ale_pkg::with_sign(u_rsp.res, !a_reg[63]);
                    i_next   = i_reg + 4'd1;
                    if (i_reg == m_reg)
                    begin
                        state_next = ale_pkg::ST_CHK;
                    end
                    else
                    begin
                        state_next = ale_pkg::ST_PMM_C;
                    end
                end
            end
            ale_pkg::ST_CHK:
            begin
                if (l_reg == m_reg)
                begin
                    res_next   = plo_reg;
                    state_next = ale_pkg::ST_OUT;
                end
                else
                begin
                    state_next = ale_pkg::ST_PH_C;
                end
            end
            ale_pkg::ST_PH_C:
            begin
                u_req.op  = ale_pkg::OP_MUL;
                u_req.opa = ale_pkg::mag(plo_reg);
                u_req.opb = {26'd0, {m_reg, 1'b1}};
                if (u_rsp.done)
                begin
                    a_next     = ale_pkg::with_sign(u_rsp.res, plo_reg[63]);
                    state_next = ale_pkg::ST_PH_X;
                end
            end
            ale_pkg::ST_PH_X:
            begin
                u_req.op  = ale_pkg::OP_MUL;
                u_req.rnd = 1'b1;
                u_req.opa = ale_pkg::mag(a_reg);
                u_req.opb = ux[30:0];
                if (u_rsp.done)
                begin
                    phi_next   = ale_pkg::with_sign(u_rsp.res, a_reg[63] ^ x_reg[31]);
                    k_next     = m_reg + 4'd2;
                    state_next = ale_pkg::ST_RCHK;
                end
            end
            ale_pkg::ST_RCHK:
            begin
                if (k_reg > l_reg)
                begin
                    res_next   = phi_reg;
                    state_next = ale_pkg::ST_OUT;
                end
                else
                begin
                    state_next = ale_pkg::ST_RA_C;
                end
            end
            ale_pkg::ST_RA_C:
            begin
                u_req.op  = ale_pkg::OP_MUL;
                u_req.opa = ale_pkg::mag(phi_reg);
                u_req.opb = {26'd0, 5'({k_reg, 1'b0}) - 5'd1};
                if (u_rsp.done)
                begin
                    a_next     = ale_pkg::with_sign(u_rsp.res, phi_reg[63]);
                    state_next = ale_pkg::ST_RA_X;
                end
            end
            ale_pkg::ST_RA_X:
            begin
                u_req.op  = ale_pkg::OP_MUL;
                u_req.rnd = 1'b1;
                u_req.opa = ale_pkg::mag(a_reg);
                u_req.opb = ux[30:0];
                if (u_rsp.done)
                begin
                    a_next     = ale_pkg::with_sign(u_rsp.res, a_reg[63] ^ x_reg[31]);
                    state_next = ale_pkg::ST_RB_C;
                end
            end
            ale_pkg::ST_RB_C:
            begin
                // subtract (k+m-1) * P_{k-2}
                u_req.op  = ale_pkg::OP_MUL;
                u_req.opa = ale_pkg::mag(plo_reg);
                u_req.opb = {26'd0, 5'({1'b0, k_reg} + {1'b0, m_reg} - 5'd1)};
                if (u_rsp.done)
                begin
                    a_next     = a_reg - ale_pkg::with_sign(u_rsp.res, plo_reg[63]);
                    state_next = ale_pkg::ST_RDIV;
                end
            end
            ale_pkg::ST_RDIV:
            begin
                u_req.op  = ale_pkg::OP_DIV;
                u_req.opa = ale_pkg::mag(a_reg);
                u_req.opb = {27'd0, k_reg - m_reg};
                if (u_rsp.done)
                begin
                    plo_next   = phi_reg;
                    phi_next   = ale_pkg::with_sign(u_rsp.res, a_reg[63]);
                    k_next     = k_reg + 4'd1;
                    state_next = ale_pkg::ST_RCHK;
                end
            end
            ale_pkg::ST_OUT:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next    = 1'b1;
                    od_next    = sat[55:0];
                    ob_next    = bad_reg;
                    state_next = ale_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ale_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ale_pkg::ST_IDLE;
            issued_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            ov_reg     <= ov_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        l_reg   <= l_next;
        m_reg   <= m_next;
        x_reg   <= x_next;
        k_reg   <= k_next;
        i_reg   <= i_next;
        plo_reg <= plo_next;
        phi_reg <= phi_next;
        a_reg   <= a_next;
        s_reg   <= s_next;
        res_reg <= res_next;
        bad_reg <= bad_next;
        od_reg  <= od_next;
        ob_reg  <= ob_next;
    end

    assign s_tready = (state_reg == ale_pkg::ST_IDLE);
    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tuser  = ob_reg;

    // a unit result only comes back for a request that was issued
    a_done_issued: assert property (@(posedge clk) disable iff (!rst_n)
        u_rsp.done |-> issued_reg)
        else $error("unit done without a pending request");

    // a flagged result carries a zero value
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == 56'd0))
        else $error("bad_args result with nonzero value");

    // an item with bad arguments goes straight to the output stage
    a_bad_path: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && in_bad) |=> (state_reg == ale_pkg::ST_OUT))
        else $error("bad arguments not short-cut");

    // no request is issued while the sequencer is idle
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ale_pkg::ST_IDLE) |-> !u_req.start)
        else $error("unit started while idle");

endmodule
